### sv/psg_pkg.sv
// package: shared codes, constants and the result type of the pulse/saw sound generator
`timescale 1ns / 1ps

package psg_pkg;

   // request kinds carried in tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // channel base addresses, address bits 15..4
   localparam logic [11:0] BASE_PULSE_A = 12'h900;
   localparam logic [11:0] BASE_PULSE_B = 12'hA00;
   localparam logic [11:0] BASE_SAW     = 12'hB00;

   // register offsets within a channel, address bits 3..0
   localparam logic [3:0] REG_CTRL      = 4'h0;
   localparam logic [3:0] REG_PERIOD_LO = 4'h1;
   localparam logic [3:0] REG_PERIOD_HI = 4'h2;

   // configuration register indexes
   localparam int          CSR_INDEX_W    = 2;
   localparam logic [1:0]  CSR_MIX_PULSE_A = 2'd0;
   localparam logic [1:0]  CSR_MIX_PULSE_B = 2'd1;
   localparam logic [1:0]  CSR_MIX_SAW     = 2'd2;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = 5;

   localparam logic [2:0] SAW_LAST_PHASE = 3'd6;

   typedef struct packed {
      logic [5:0] mixed_sum;
      logic [4:0] saw_level;
      logic [3:0] pulse_b_level;
      logic [3:0] pulse_a_level;
   } rsp_type;

endpackage

### sv/pulse_saw_sound_generator_core.sv
// top level: two pulse channels and one sawtooth channel with level mixer
//
//  channel | direction | handshake           | payload
//  req     | in        | req_tvalid/tready   | tuser operation, tdata address/value/cycles
//  rsp     | out       | rsp_tvalid/tready   | tdata pulse_a/pulse_b/saw levels, mixed sum
//  csr     | in        | csr_we              | csr_index, csr_wdata (mix enables)
//
// one request is taken per cycle while req_tready is high; its result is registered on rsp
// at acceptance, or in the skid entry when an older result is still waiting there.
// all channel state is updated in the cycle of acceptance by the timer/decode logic.
// a two-entry result buffer lets requests keep flowing while one result waits;
// req_tready drops only when both entries are full.
// reset (synchronous) clears channel state and the buffer and sets all mix enables.
`timescale 1ns / 1ps

module pulse_saw_sound_generator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // address [15:0], value [23:16], cycles [31:24]
   input  logic [psg_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation [0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pulse_a_level [3:0], pulse_b_level [7:4], saw_level [12:8], mixed_sum [18:13], zero pad
   output logic [psg_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [psg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic                               csr_wdata
);
   import psg_pkg::*;

   // mix enables
   logic mix_a_ff, mix_b_ff, mix_saw_ff;

   // pulse channel state
   logic [15:0] pulse_countdown_ff [2];
   logic [15:0] pulse_countdown_in [2];
   logic [11:0] pulse_period_ff    [2];
   logic [11:0] pulse_period_in    [2];
   logic [3:0]  pulse_volume_ff    [2];
   logic [3:0]  pulse_volume_in    [2];
   logic [2:0]  pulse_duty_ff      [2];
   logic [2:0]  pulse_duty_in      [2];
   logic        pulse_force_ff     [2];
   logic        pulse_force_in     [2];
   logic        pulse_on_ff        [2];
   logic        pulse_on_in        [2];
   logic [3:0]  pulse_phase_ff     [2];
   logic [3:0]  pulse_phase_in     [2];
   logic [3:0]  pulse_out_ff       [2];
   logic [3:0]  pulse_out_in       [2];

   // saw channel state
   logic [15:0] saw_countdown_ff, saw_countdown_in;
   logic [11:0] saw_period_ff, saw_period_in;
   logic [5:0]  saw_rate_ff, saw_rate_in;
   logic        saw_on_ff, saw_on_in;
   logic [2:0]  saw_phase_ff, saw_phase_in;
   logic [7:0]  saw_acc_ff, saw_acc_in;
   logic [4:0]  saw_out_ff, saw_out_in;

   // result buffer
   rsp_type rsp_ff, skid_ff, rsp_new;
   logic    rsp_valid_ff, skid_valid_ff;

   logic        accept, pop;
   logic        op;
   logic [15:0] address;
   logic [7:0]  value;
   logic [15:0] cycles_ext;
   logic [11:0] base;
   logic [3:0]  offset;
   logic        sel_pulse [2];
   logic        sel_saw;

   assign op         = req_tuser;
   assign address    = req_tdata[15:0];
   assign value      = req_tdata[23:16];
   assign cycles_ext = {8'd0, req_tdata[31:24]};
   assign base       = address[15:4];
   assign offset     = address[3:0];
   assign sel_pulse[0] = (op == OP_WRITE) && (base == BASE_PULSE_A);
   assign sel_pulse[1] = (op == OP_WRITE) && (base == BASE_PULSE_B);
   assign sel_saw      = (op == OP_WRITE) && (base == BASE_SAW);

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_valid_ff && rsp_tready;

   // pulse channels
   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         logic signed [15:0] t_sub;
         logic signed [15:0] reload;
         logic               expire;
         pulse_countdown_in[ch] = pulse_countdown_ff[ch];
         pulse_period_in[ch]    = pulse_period_ff[ch];
         pulse_volume_in[ch]    = pulse_volume_ff[ch];
         pulse_duty_in[ch]      = pulse_duty_ff[ch];
         pulse_force_in[ch]     = pulse_force_ff[ch];
         pulse_on_in[ch]        = pulse_on_ff[ch];
         pulse_phase_in[ch]     = pulse_phase_ff[ch];
         pulse_out_in[ch]       = pulse_out_ff[ch];

         // timer subtracts only while positive
         t_sub  = ($signed(pulse_countdown_ff[ch]) > 16'sd0)
                  ? $signed(pulse_countdown_ff[ch]) - $signed(cycles_ext)
                  : $signed(pulse_countdown_ff[ch]);
         reload = $signed({4'd0, pulse_period_ff[ch]}) + 16'sd1;
         expire = (t_sub <= 16'sd0);

         if (op == OP_TICK) begin
            if (expire) begin
               pulse_countdown_in[ch] = 16'(t_sub + reload);
               if (pulse_on_ff[ch] &&
                   (pulse_force_ff[ch] || (pulse_phase_ff[ch] <= {1'b0, pulse_duty_ff[ch]})))
                  pulse_out_in[ch] = pulse_volume_ff[ch];
               else
                  pulse_out_in[ch] = 4'd0;
               pulse_phase_in[ch] = pulse_phase_ff[ch] + 4'd1;
            end else begin
               pulse_countdown_in[ch] = 16'(t_sub);
            end
         end else if (sel_pulse[ch]) begin
            unique case (offset)
               REG_CTRL: begin
                  pulse_volume_in[ch] = value[3:0];
                  pulse_duty_in[ch]   = value[6:4];
                  pulse_force_in[ch]  = value[7];
                  if (value[7])
                     pulse_out_in[ch] = value[3:0];
               end
               REG_PERIOD_LO: begin
                  pulse_period_in[ch] = {pulse_period_ff[ch][11:8], value};
               end
               REG_PERIOD_HI: begin
                  pulse_on_in[ch] = value[7];
                  if (!value[7])
                     pulse_out_in[ch] = 4'd0;
                  pulse_period_in[ch] = {value[3:0], pulse_period_ff[ch][7:0]};
               end
               default: ;
            endcase
         end
      end
   end

   // sawtooth channel
   always_comb begin
      logic signed [15:0] t_sub;
      logic signed [15:0] reload;
      logic               expire;
      logic [7:0]         acc_sum;
      saw_countdown_in = saw_countdown_ff;
      saw_period_in    = saw_period_ff;
      saw_rate_in      = saw_rate_ff;
      saw_on_in        = saw_on_ff;
      saw_phase_in     = saw_phase_ff;
      saw_acc_in       = saw_acc_ff;
      saw_out_in       = saw_out_ff;

      t_sub   = ($signed(saw_countdown_ff) > 16'sd0)
                ? $signed(saw_countdown_ff) - $signed(cycles_ext)
                : $signed(saw_countdown_ff);
      // reload is twice (period + 1)
      reload  = $signed({3'd0, saw_period_ff, 1'b0}) + 16'sd2;
      expire  = (t_sub <= 16'sd0);
      acc_sum = saw_acc_ff + {2'd0, saw_rate_ff};

      if (op == OP_TICK) begin
         if (expire) begin
            saw_countdown_in = 16'(t_sub + reload);
            if (saw_phase_ff == SAW_LAST_PHASE) begin
               // ramp restarts, output held
               saw_phase_in = 3'd0;
               saw_acc_in   = 8'd0;
            end else begin
               saw_phase_in = saw_phase_ff + 3'd1;
               if (!saw_on_ff) begin
                  saw_out_in = 5'd0;
               end else begin
                  saw_acc_in = acc_sum;
                  saw_out_in = acc_sum[7:3];
               end
            end
         end else begin
            saw_countdown_in = 16'(t_sub);
         end
      end else if (sel_saw) begin
         unique case (offset)
            REG_CTRL: begin
               saw_rate_in = value[5:0];
            end
            REG_PERIOD_LO: begin
               saw_period_in = {saw_period_ff[11:8], value};
            end
            REG_PERIOD_HI: begin
               saw_on_in = value[7];
               if (!value[7])
                  saw_out_in = 5'd0;
               saw_period_in = {value[3:0], saw_period_ff[7:0]};
            end
            default: ;
         endcase
      end
   end

   // levels and mix of the updated state
   always_comb begin
      rsp_new.pulse_a_level = pulse_out_in[0];
      rsp_new.pulse_b_level = pulse_out_in[1];
      rsp_new.saw_level     = saw_out_in;
      rsp_new.mixed_sum     = (mix_a_ff ? {2'd0, pulse_out_in[0]} : 6'd0)
                            + (mix_b_ff ? {2'd0, pulse_out_in[1]} : 6'd0)
                            + (mix_saw_ff ? {1'b0, saw_out_in} : 6'd0);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mix_a_ff   <= 1'b1;
         mix_b_ff   <= 1'b1;
         mix_saw_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIX_PULSE_A: mix_a_ff   <= csr_wdata;
            CSR_MIX_PULSE_B: mix_b_ff   <= csr_wdata;
            CSR_MIX_SAW:     mix_saw_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < 2; ch++) begin
            pulse_countdown_ff[ch] <= 16'd0;
            pulse_period_ff[ch]    <= 12'd0;
            pulse_volume_ff[ch]    <= 4'd0;
            pulse_duty_ff[ch]      <= 3'd0;
            pulse_force_ff[ch]     <= 1'b0;
            pulse_on_ff[ch]        <= 1'b0;
            pulse_phase_ff[ch]     <= 4'd0;
            pulse_out_ff[ch]       <= 4'd0;
         end
         saw_countdown_ff <= 16'd0;
         saw_period_ff    <= 12'd0;
         saw_rate_ff      <= 6'd0;
         saw_on_ff        <= 1'b0;
         saw_phase_ff     <= 3'd0;
         saw_acc_ff       <= 8'd0;
         saw_out_ff       <= 5'd0;
      end else if (accept) begin
         for (int ch = 0; ch < 2; ch++) begin
            pulse_countdown_ff[ch] <= pulse_countdown_in[ch];
            pulse_period_ff[ch]    <= pulse_period_in[ch];
            pulse_volume_ff[ch]    <= pulse_volume_in[ch];
            pulse_duty_ff[ch]      <= pulse_duty_in[ch];
            pulse_force_ff[ch]     <= pulse_force_in[ch];
            pulse_on_ff[ch]        <= pulse_on_in[ch];
            pulse_phase_ff[ch]     <= pulse_phase_in[ch];
            pulse_out_ff[ch]       <= pulse_out_in[ch];
         end
         saw_countdown_ff <= saw_countdown_in;
         saw_period_ff    <= saw_period_in;
         saw_rate_ff      <= saw_rate_in;
         saw_on_ff        <= saw_on_in;
         saw_phase_ff     <= saw_phase_in;
         saw_acc_ff       <= saw_acc_in;
         saw_out_ff       <= saw_out_in;
      end
   end

   // two-entry result buffer: output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (rsp_valid_ff && !pop) begin
            skid_ff       <= rsp_new;
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_ff       <= rsp_new;
            rsp_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff};

endmodule

### sv/psg_checker.sv
// checker: port-level assertions for the pulse/saw sound generator, bound to the top level
`timescale 1ns / 1ps

module psg_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [psg_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import psg_pkg::*;

   logic [6:0] level_total;
   assign level_total = {3'd0, rsp_tdata[3:0]} + {3'd0, rsp_tdata[7:4]}
                      + {2'd0, rsp_tdata[12:8]};

   // buffer full only while a result is shown
   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no result pending");

   // after every accepted request a result is shown on the output in the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // mix never exceeds the sum of the three levels, and the pad bits stay zero
   a_mix_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[18:13]} <= level_total)
                     && (rsp_tdata[RSP_DATA_W-1:19] == '0))
      else $error("mixed sum out of range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset left a result pending");

endmodule

bind pulse_saw_sound_generator_core psg_checker u_psg_checker (.*);

### tb/sv/pulse_saw_sound_generator_core_test.sv
// testbench: pulse/saw sound generator core checked request by request against a level predictor
`timescale 1ns / 1ps

module pulse_saw_sound_generator_core_test;
   import psg_pkg::*;

   localparam int          ITEMS_PER_PHASE = 180;
   localparam int          PHASE_COUNT     = 6;
   localparam int          STALL_LIMIT     = 2000;
   localparam int          LONG_HOLD       = 120;
   localparam logic [1:0]  CSR_UNUSED      = 2'd3;

   typedef struct packed {
      logic        op;
      logic [15:0] addr;
      logic [7:0]  val;
      logic [7:0]  cyc;
      logic        known;
      logic [3:0]  lvl_a;
      logic [3:0]  lvl_b;
      logic [4:0]  lvl_s;
      logic [5:0]  sum;
   } directed_row_type;

   typedef struct packed {
      logic        op;
      logic [15:0] addr;
      logic [7:0]  val;
      logic [7:0]  cyc;
      logic        known;
      rsp_type     want;
   } sound_req_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_W-1:0]     req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]     rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic                      csr_wdata = 1'b0;

   pulse_saw_sound_generator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predicted chip state
   logic signed [15:0] pulse_cnt [2];
   logic [11:0]        pulse_per [2];
   logic [3:0]         pulse_vol [2];
   logic [2:0]         pulse_dty [2];
   logic               pulse_frc [2];
   logic               pulse_en  [2];
   logic [3:0]         pulse_ph  [2];
   logic [3:0]         pulse_lvl [2];
   logic signed [15:0] saw_cnt;
   logic [11:0]        saw_per;
   logic [5:0]         saw_rt;
   logic               saw_en;
   logic [2:0]         saw_ph;
   logic [7:0]         saw_acc;
   logic [4:0]         saw_lvl;
   logic               mix_a, mix_b, mix_s;

   sound_req_type pending_requests[$];
   rsp_type    expected_levels[$];
   rsp_type    rsp_got, rsp_want;
   int         snd_idle_pct = 22;
   int         rcv_idle_pct = 50;
   int         hold_left = 0;
   bit         hold_trigger = 1'b0;
   int         mismatches = 0;
   int         results_seen = 0;
   int         quiet_cycles = 0;

   directed_row_type directed_rows [26] = '{
      // after reset every level is zero
      '{OP_TICK,  16'h0000, 8'h00, 8'h00, 1'b1, 4'd0,  4'd0,  5'd0, 6'd0},
      // forced volume shows at once, even with the channel off
      '{OP_WRITE, 16'h9000, 8'h8F, 8'h00, 1'b1, 4'd15, 4'd0,  5'd0, 6'd15},
      '{OP_WRITE, 16'hA000, 8'hFF, 8'h00, 1'b1, 4'd15, 4'd15, 5'd0, 6'd30},
      // clearing enable zeroes the output
      '{OP_WRITE, 16'h9002, 8'h00, 8'h00, 1'b1, 4'd0,  4'd15, 5'd0, 6'd15},
      '{OP_WRITE, 16'hA002, 8'h00, 8'hFF, 1'b1, 4'd0,  4'd0,  5'd0, 6'd0},
      // addresses that decode to nothing
      '{OP_WRITE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'h9003, 8'hFF, 8'h00, 1'b1, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'h0000, 8'h00, 8'h00, 1'b1, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'hB010, 8'hFF, 8'h00, 1'b1, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'h9000, 8'h3A, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'h9001, 8'h05, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'h9002, 8'h80, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'hA000, 8'h7F, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'hA001, 8'hFF, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'hA002, 8'h8F, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'hB000, 8'hFF, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'hB001, 8'h00, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'hB002, 8'h80, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      // long tick drives the pulse A and saw timers negative; the zero tick then reloads without subtracting
      '{OP_TICK,  16'hFFFF, 8'hFF, 8'hFF, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_TICK,  16'h0000, 8'h00, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_TICK,  16'h9000, 8'h00, 8'h01, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_TICK,  16'h0000, 8'hAA, 8'h03, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'h9000, 8'hCF, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_TICK,  16'h5555, 8'h55, 8'hFF, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_WRITE, 16'hB002, 8'h00, 8'h00, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0},
      '{OP_TICK,  16'h0000, 8'h00, 8'h07, 1'b0, 4'd0,  4'd0,  5'd0, 6'd0}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit countdown_expired(input int cnt, input int cyc, input int reload,
                                            output int next_cnt);
      next_cnt = cnt;
      if (next_cnt > 0) begin
         next_cnt = next_cnt - cyc;
         if (next_cnt > 0) return 1'b0;
      end
      next_cnt = next_cnt + reload;
      return 1'b1;
   endfunction

   function automatic void pulse_write(input int ch, input logic [3:0] rg, input logic [7:0] v);
      case (rg)
         REG_CTRL: begin
            pulse_vol[ch] = v[3:0];
            pulse_dty[ch] = v[6:4];
            pulse_frc[ch] = v[7];
            if (v[7]) pulse_lvl[ch] = v[3:0];
         end
         REG_PERIOD_LO: pulse_per[ch][7:0] = v;
         REG_PERIOD_HI: begin
            pulse_en[ch] = v[7];
            if (!v[7]) pulse_lvl[ch] = 4'd0;
            pulse_per[ch][11:8] = v[3:0];
         end
         default: ;
      endcase
   endfunction

   function automatic void saw_write(input logic [3:0] rg, input logic [7:0] v);
      case (rg)
         REG_CTRL:      saw_rt = v[5:0];
         REG_PERIOD_LO: saw_per[7:0] = v;
         REG_PERIOD_HI: begin
            saw_en = v[7];
            if (!v[7]) saw_lvl = 5'd0;
            saw_per[11:8] = v[3:0];
         end
         default: ;
      endcase
   endfunction

   function automatic void pulse_advance(input int ch, input int cyc);
      int nxt;
      bit fired;
      fired = countdown_expired(int'(pulse_cnt[ch]), cyc, int'(pulse_per[ch]) + 1, nxt);
      pulse_cnt[ch] = nxt[15:0];
      if (fired) begin
         if (pulse_en[ch] && (pulse_frc[ch] || pulse_ph[ch] <= {1'b0, pulse_dty[ch]}))
            pulse_lvl[ch] = pulse_vol[ch];
         else
            pulse_lvl[ch] = 4'd0;
         pulse_ph[ch] = pulse_ph[ch] + 4'd1;
      end
   endfunction

   function automatic void saw_advance(input int cyc);
      int nxt;
      bit fired;
      fired = countdown_expired(int'(saw_cnt), cyc, (int'(saw_per) + 1) * 2, nxt);
      saw_cnt = nxt[15:0];
      if (fired) begin
         if (saw_ph == SAW_LAST_PHASE) begin
            // end of ramp: restart, output holds
            saw_ph = 3'd0;
            saw_acc = 8'd0;
         end else begin
            saw_ph = saw_ph + 3'd1;
            if (!saw_en) begin
               saw_lvl = 5'd0;
            end else begin
               saw_acc = saw_acc + {2'b00, saw_rt};
               saw_lvl = saw_acc[7:3];
            end
         end
      end
   endfunction

   function automatic rsp_type sound_step(input logic op, input logic [15:0] addr,
                                          input logic [7:0] val, input logic [7:0] cyc);
      rsp_type lvl;
      logic [5:0] total;
      if (op == OP_WRITE) begin
         if (addr[15:4] == BASE_PULSE_A)      pulse_write(0, addr[3:0], val);
         else if (addr[15:4] == BASE_PULSE_B) pulse_write(1, addr[3:0], val);
         else if (addr[15:4] == BASE_SAW)     saw_write(addr[3:0], val);
      end else begin
         pulse_advance(0, int'(cyc));
         pulse_advance(1, int'(cyc));
         saw_advance(int'(cyc));
      end
      total = 6'd0;
      if (mix_a) total = total + {2'b00, pulse_lvl[0]};
      if (mix_b) total = total + {2'b00, pulse_lvl[1]};
      if (mix_s) total = total + {1'b0, saw_lvl};
      lvl.pulse_a_level = pulse_lvl[0];
      lvl.pulse_b_level = pulse_lvl[1];
      lvl.saw_level     = saw_lvl;
      lvl.mixed_sum     = total;
      return lvl;
   endfunction

   function automatic sound_req_type random_request();
      sound_req_type it;
      logic [11:0] base;
      int pick;
      pick = int'($urandom_range(0, 99));
      it.addr  = 16'($urandom);
      it.val   = 8'($urandom);
      it.cyc   = 8'($urandom);
      it.known = 1'b0;
      it.want  = '0;
      case ($urandom_range(0, 2))
         0:       base = BASE_PULSE_A;
         1:       base = BASE_PULSE_B;
         default: base = BASE_SAW;
      endcase
      if (pick < 45) begin
         it.op = OP_TICK;
         // mostly short ticks so the waveforms step often
         if ($urandom_range(0, 9) < 7) it.cyc = 8'($urandom_range(0, 31));
      end else if (pick < 90) begin
         it.op = OP_WRITE;
         case ($urandom_range(0, 2))
            0: it.addr = {base, REG_CTRL};
            1: it.addr = {base, REG_PERIOD_LO};
            default: begin
               it.addr = {base, REG_PERIOD_HI};
               // keep periods short and channels mostly on
               if ($urandom_range(0, 9) != 0) it.val[3:0] = 4'd0;
               if ($urandom_range(0, 4) != 0) it.val[7] = 1'b1;
            end
         endcase
      end else begin
         it.op = OP_WRITE;
         if ($urandom_range(0, 1) != 0) it.addr = {base, 4'($urandom_range(3, 15))};
      end
      return it;
   endfunction

   function automatic void accept_request(input sound_req_type it);
      rsp_type want;
      want = sound_step(it.op, it.addr, it.val, it.cyc);
      if (it.known) want = it.want;
      expected_levels.push_back(want);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
      mismatches++;
   endtask

   task automatic write_mix(input logic [1:0] idx, input logic v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_MIX_PULSE_A: mix_a = v;
         CSR_MIX_PULSE_B: mix_b = v;
         CSR_MIX_SAW:     mix_s = v;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_levels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [2:0] phase_mix(input int ph);
      case (ph)
         0:       return 3'b111;
         1:       return 3'b000;
         2:       return 3'b101;
         3:       return 3'b010;
         4:       return 3'b110;
         default: return 3'b001;
      endcase
   endfunction

   // request side: offer queued requests, run the predictor on each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) accept_request(pending_requests.pop_front());
         if (req_tvalid && !req_tready) begin
            // hold the request on the bus until taken
         end else if (pending_requests.size() != 0 &&
                      $urandom_range(0, 99) >= snd_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {pending_requests[0].cyc, pending_requests[0].val,
                           pending_requests[0].addr};
            req_tuser  <= pending_requests[0].op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side: compare against the oldest expectation, pace rsp_tready
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         rsp_got = rsp_tdata[$bits(rsp_type)-1:0];
         if (expected_levels.size() == 0) begin
            report_mismatch("unexpected result, mixed_sum", int'(rsp_got.mixed_sum), 0);
         end else begin
            rsp_want = expected_levels.pop_front();
            if (rsp_got.pulse_a_level !== rsp_want.pulse_a_level)
               report_mismatch("pulse_a_level", int'(rsp_got.pulse_a_level),
                               int'(rsp_want.pulse_a_level));
            if (rsp_got.pulse_b_level !== rsp_want.pulse_b_level)
               report_mismatch("pulse_b_level", int'(rsp_got.pulse_b_level),
                               int'(rsp_want.pulse_b_level));
            if (rsp_got.saw_level !== rsp_want.saw_level)
               report_mismatch("saw_level", int'(rsp_got.saw_level),
                               int'(rsp_want.saw_level));
            if (rsp_got.mixed_sum !== rsp_want.mixed_sum)
               report_mismatch("mixed_sum", int'(rsp_got.mixed_sum),
                               int'(rsp_want.mixed_sum));
         end
         results_seen++;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_trigger) begin
         hold_trigger = 1'b0;
         rsp_tready <= 1'b0;
         hold_left  <= LONG_HOLD;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("pulse_saw_sound_generator_core verification failed");
            $finish;
         end
      end
   end

   initial begin : main_flow
      sound_req_type it;
      logic [2:0] mix;
      int ph, n;
      for (int ch = 0; ch < 2; ch++) begin
         pulse_cnt[ch] = '0;
         pulse_per[ch] = '0;
         pulse_vol[ch] = '0;
         pulse_dty[ch] = '0;
         pulse_frc[ch] = 1'b0;
         pulse_en[ch]  = 1'b0;
         pulse_ph[ch]  = '0;
         pulse_lvl[ch] = '0;
      end
      saw_cnt = '0;
      saw_per = '0;
      saw_rt  = '0;
      saw_en  = 1'b0;
      saw_ph  = '0;
      saw_acc = '0;
      saw_lvl = '0;
      mix_a = 1'b1;
      mix_b = 1'b1;
      mix_s = 1'b1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         it.op    = directed_rows[i].op;
         it.addr  = directed_rows[i].addr;
         it.val   = directed_rows[i].val;
         it.cyc   = directed_rows[i].cyc;
         it.known = directed_rows[i].known;
         it.want.pulse_a_level = directed_rows[i].lvl_a;
         it.want.pulse_b_level = directed_rows[i].lvl_b;
         it.want.saw_level     = directed_rows[i].lvl_s;
         it.want.mixed_sum     = directed_rows[i].sum;
         pending_requests.push_back(it);
      end
      wait_drained();

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         mix = phase_mix(ph);
         write_mix(CSR_MIX_PULSE_A, mix[2]);
         write_mix(CSR_MIX_PULSE_B, mix[1]);
         write_mix(CSR_MIX_SAW, mix[0]);
         // out-of-range index must not touch any enable
         if (ph == 0) write_mix(CSR_UNUSED, 1'b0);
         @(posedge clock);
         csr_we <= 1'b0;
         case (ph / 2)
            0: begin snd_idle_pct = 22; rcv_idle_pct = 50; end
            1: begin snd_idle_pct = 50; rcv_idle_pct = 22; end
            default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // sender pause: let every result come home mid-phase
            if (ph == 3 && n == ITEMS_PER_PHASE / 2) wait_drained();
            pending_requests.push_back(random_request());
         end
         // long receiver hold-off while requests keep coming
         if (ph == 2) hold_trigger = 1'b1;
         wait_drained();
      end

      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("pulse_saw_sound_generator_core verification clean");
      else
         $display("pulse_saw_sound_generator_core verification failed");
      $finish;
   end

endmodule

### sim.f
sv/psg_pkg.sv
sv/pulse_saw_sound_generator_core.sv
sv/psg_checker.sv
tb/sv/pulse_saw_sound_generator_core_test.sv
